// File: hw/rtl/krs_pkg.sv
// Shared types and constants for the key release synthesizer.
`default_nettype none
package krs_pkg;

  localparam int KEY_W  = 8;
  localparam int TIME_W = 32;
  localparam int HOLD_W = 16;
  localparam int KIND_W = 2;

  // Input item kinds
  localparam logic [KIND_W-1:0] KIND_ARRIVE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SCAN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_HOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_HOLD  = 2'd1;

  localparam logic [HOLD_W-1:0] RESET_INITIAL_HOLD = 16'd600;
  localparam logic [HOLD_W-1:0] RESET_REPEAT_HOLD  = 16'd120;

  // Reported queue count saturates here
  localparam int COUNT_W = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // Command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = 1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ARRIVE,
    OP_SCAN,
    OP_POP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [HOLD_W-1:0] initial_hold;
    logic [HOLD_W-1:0] repeat_hold;
  } hold_cfg_t;

  typedef struct packed {
    logic               valid;
    logic               pressed;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic               dropped;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/krs_front.sv
// Front end: accepts input items, classifies them and queues commands.
`default_nettype none
module krs_front import krs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [KEY_W-1:0]  key_code,
  input  logic [TIME_W-1:0] now_ms,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_take
);

  cmd_t                 fifo [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_PTR_W:0]   fill;
  cmd_t                 cmd_in;
  logic                 push;

  // Classify the item; a zero key arrival and the unused kind do nothing
  always_comb begin
    cmd_in.key = key_code;
    cmd_in.now = now_ms;
    unique case (kind)
      KIND_ARRIVE: cmd_in.op = (key_code == '0) ? OP_NONE : OP_ARRIVE;
      KIND_SCAN:   cmd_in.op = OP_SCAN;
      KIND_POP:    cmd_in.op = OP_POP;
      default:     cmd_in.op = OP_NONE;
    endcase
  end

  assign in_stall  = (fill == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != '0);
  assign cmd       = fifo[rd_ptr];

  // Store queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cmd_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, cmd_take})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/krs_engine.sv
// Back end: held-key table, expiry scan, event ring and result register.
`default_nettype none
module krs_engine import krs_pkg::*; #(
  parameter int HELD_SLOTS  = 8,
  parameter int QUEUE_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  input  hold_cfg_t hold,
  output logic      res_valid,
  output result_t   res,
  input  logic      res_stall
);

  localparam int SLOT_W = $clog2(HELD_SLOTS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int SAT_W  = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;
  localparam int EVT_W  = KEY_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ARRIVE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_POP    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state;
  cmd_t   cur;

  logic [KEY_W-1:0]      slot_code [HELD_SLOTS];
  logic [TIME_W-1:0]     slot_time [HELD_SLOTS];
  logic [HELD_SLOTS-1:0] slot_repeat;

  logic [EVT_W-1:0] ring [QUEUE_DEPTH];
  logic [EVT_W-1:0] rd_data;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] count;
  logic [PTR_W-1:0] count_next;

  logic [SLOT_W-1:0] scan_idx;
  logic              lost;
  logic              pop_hit;

  logic [HELD_SLOTS-1:0] hit;
  logic [HELD_SLOTS-1:0] free;
  logic [HELD_SLOTS-1:0] first_free;
  logic                  any_hit;
  logic                  any_free;

  logic [KEY_W-1:0]  sc_code;
  logic [TIME_W-1:0] sc_time;
  logic [HOLD_W-1:0] sc_limit;
  logic [TIME_W-1:0] elapsed;
  logic              expire;

  logic             ring_full;
  logic             push_req;
  logic [EVT_W-1:0] push_data;
  logic             push_ok;
  logic             push_drop;
  logic             pop_go;
  logic             res_free;

  logic [SAT_W-1:0]   count_wide;
  logic [COUNT_W-1:0] count_sat;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Compare the arriving key against every slot
  always_comb begin
    for (int i = 0; i < HELD_SLOTS; i++) begin
      hit[i]  = (slot_code[i] == cur.key);
      free[i] = (slot_code[i] == '0);
    end
  end

  // Isolate the lowest free slot
  assign first_free = free & (~free + HELD_SLOTS'(1));
  assign any_hit    = |hit;
  assign any_free   = |free;

  // Check the slot under the scan pointer
  assign sc_code  = slot_code[scan_idx];
  assign sc_time  = slot_time[scan_idx];
  assign sc_limit = slot_repeat[scan_idx] ? hold.repeat_hold : hold.initial_hold;
  assign elapsed  = cur.now - sc_time;
  assign expire   = (sc_code != '0) && (elapsed > TIME_W'(sc_limit));

  // Choose the event to queue this cycle
  always_comb begin
    push_req  = 1'b0;
    push_data = {1'b1, cur.key};
    if (state == ST_ARRIVE) begin
      push_req = !any_hit && any_free;
    end else if (state == ST_SCAN) begin
      push_req  = expire;
      push_data = {1'b0, sc_code};
    end
  end

  assign ring_full = (count == PTR_W'(QUEUE_DEPTH - 1));
  assign push_ok   = push_req && !ring_full;
  assign push_drop = push_req && ring_full;
  assign pop_go    = (state == ST_POP) && (count != '0);
  assign res_free  = !res_valid || !res_stall;
  assign cmd_take  = (state == ST_IDLE) && cmd_valid;

  always_comb begin
    unique case ({push_ok, pop_go})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  // Saturate the reported count
  assign count_wide = SAT_W'(count);
  assign count_sat  = (count_wide > SAT_W'(COUNT_MAX)) ? COUNT_MAX
                                                       : count_wide[COUNT_W-1:0];

  // Event ring: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (push_ok) begin
      ring[wr_ptr] <= push_data;
    end
    if (pop_go) begin
      rd_data <= ring[rd_ptr];
    end
  end

  // Stamp slot times on refresh or claim
  always_ff @(posedge clk) begin
    if (state == ST_ARRIVE) begin
      for (int i = 0; i < HELD_SLOTS; i++) begin
        if (any_hit ? hit[i] : first_free[i]) begin
          slot_time[i] <= cur.now;
        end
      end
    end
  end

  // Update slot codes and repeat marks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HELD_SLOTS; i++) begin
        slot_code[i] <= '0;
      end
      slot_repeat <= '0;
    end else if (state == ST_ARRIVE) begin
      if (any_hit) begin
        slot_repeat <= slot_repeat | hit;
      end else begin
        for (int i = 0; i < HELD_SLOTS; i++) begin
          if (first_free[i]) begin
            slot_code[i]   <= cur.key;
            slot_repeat[i] <= 1'b0;
          end
        end
      end
    end else if ((state == ST_SCAN) && expire) begin
      slot_code[scan_idx] <= '0;
    end
  end

  // Sequence one command at a time and hold its result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      res_valid <= 1'b0;
      lost      <= 1'b0;
      pop_hit   <= 1'b0;
      scan_idx  <= '0;
    end else begin
      if (res_valid && !res_stall && (state != ST_DONE)) begin
        res_valid <= 1'b0;
      end
      count <= count_next;
      if (push_ok) begin
        wr_ptr <= ring_next(wr_ptr);
      end
      if (pop_go) begin
        rd_ptr <= ring_next(rd_ptr);
      end
      if (push_drop) begin
        lost <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          lost     <= 1'b0;
          pop_hit  <= 1'b0;
          scan_idx <= '0;
          if (cmd_valid) begin
            cur <= cmd;
            unique case (cmd.op)
              OP_ARRIVE: state <= ST_ARRIVE;
              OP_SCAN:   state <= ST_SCAN;
              OP_POP:    state <= ST_POP;
              default:   state <= ST_DONE;
            endcase
          end
        end
        ST_ARRIVE: begin
          state <= ST_DONE;
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == SLOT_W'(HELD_SLOTS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_POP: begin
          pop_hit <= (count != '0);
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (res_free) begin
            res_valid   <= 1'b1;
            res.valid   <= pop_hit;
            res.pressed <= pop_hit & rd_data[KEY_W];
            res.key     <= pop_hit ? rd_data[KEY_W-1:0] : '0;
            res.count   <= count_sat;
            res.dropped <= lost;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/key_release_synthesizer.sv
// Top level of the key release synthesizer: ports, hold registers, front and back.
`default_nettype none
// Turns a press-only stream of key codes into press and release events. Each
// input item gives exactly one result item. The front queues up to two
// classified items while the back works, so input is taken while a result
// waits; an accepted item is registered in the front queue before the back
// can take it. The back handles one item at a time: an arrival or a pop goes
// through take, work and deliver, a zero-key arrival or the unused kind
// through take and deliver, and an expiry scan through take, a visit to each
// slot and deliver; it visits one slot a cycle through a single elapsed-time
// subtract and compare and writes at most one release a cycle into the
// single-port event ring. Pop reads the ring through a registered read. The
// ring holds up to QUEUE_DEPTH - 1 events; when full, new events are dropped
// and the result flags event_dropped. The user must write hold times through
// the cfg port only while the block is idle; the block does not enforce this.
// cfg_ready is always high and indexes past the last register are ignored.
module key_release_synthesizer import krs_pkg::*; #(
  parameter int HELD_SLOTS  = 8,
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [KIND_W-1:0]      kind,
  input  logic [KEY_W-1:0]       key_code,
  input  logic [TIME_W-1:0]      now_ms,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   event_valid,
  output logic                   event_pressed,
  output logic [KEY_W-1:0]       event_key,
  output logic [COUNT_W-1:0]     queued_count,
  output logic                   event_dropped,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [HOLD_W-1:0]      cfg_data
);

  hold_cfg_t hold;
  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_take;
  result_t   res;

  assign cfg_ready = 1'b1;

  // Write hold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold.initial_hold <= RESET_INITIAL_HOLD;
      hold.repeat_hold  <= RESET_REPEAT_HOLD;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_INITIAL_HOLD) begin
        hold.initial_hold <= cfg_data;
      end else if (cfg_index == CFG_REPEAT_HOLD) begin
        hold.repeat_hold <= cfg_data;
      end
    end
  end

  krs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .key_code  (key_code),
    .now_ms    (now_ms),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  krs_engine #(
    .HELD_SLOTS  (HELD_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .hold      (hold),
    .res_valid (out_valid),
    .res       (res),
    .res_stall (out_stall)
  );

  // Split the result onto its ports
  assign event_valid   = res.valid;
  assign event_pressed = res.pressed;
  assign event_key     = res.key;
  assign queued_count  = res.count;
  assign event_dropped = res.dropped;

endmodule
`default_nettype wire

// File: hw/rtl/krs_checker.sv
// Port-level checks for the key release synthesizer, bound to the top level.
`default_nettype none
module krs_checker import krs_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   event_valid,
  input logic                   event_pressed,
  input logic [KEY_W-1:0]       event_key,
  input logic [COUNT_W-1:0]     queued_count,
  input logic                   event_dropped
);

  // No result is offered straight after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_key)
      && $stable(event_pressed) && $stable(queued_count))
    else $error("stalled result changed");

  // A result with no popped event, such as an empty pop, reports no key
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_valid |-> !event_pressed && (event_key == '0))
    else $error("empty pop carries event data");

  // Queued events always carry a real key
  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_valid |-> (event_key != '0))
    else $error("popped event with zero key");

  // A drop means the queue was full, so it cannot read empty
  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_dropped |-> (queued_count != '0))
    else $error("drop reported with empty queue");

endmodule

bind key_release_synthesizer krs_checker u_checker (.*);
`default_nettype wire
